// File: design/siq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siq_pkg: shared types and constants for the sorted insert queue
// Field widths, operation and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package siq_pkg;

  localparam int KEY_W        = 11;
  localparam int PAY_W        = 16;
  localparam int ST_W         = 2;
  localparam int LEN_W        = 5;
  localparam int ENTRY_W      = KEY_W + PAY_W;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    OP_PUSH_HEAD = 2'd0,
    OP_PUSH_TAIL = 2'd1,
    OP_INSERT    = 2'd2,
    OP_POP       = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_UP_RD,
    S_UP_WR,
    S_WRITE,
    S_POP_RD,
    S_POP_CAP,
    S_DN_RD,
    S_DN_WR,
    S_FINISH
  } state_t;

endpackage

// File: design/sorted_insert_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_queue: bounded ordered queue with stable ordered insert
// Entries live in a single-port-write, registered-read memory with the head
// in slot 0. A small sequencer scans and shifts the entries one slot at a time,
// sharing one key comparator and one index step unit.
// ----------------------------------------------------------------------------
//  channel | direction | tuser          | tdata (lowest bit up)
//  in_     | slave     | [1:0] op       | [10:0] key, [26:11] payload
//  out_    | master    | [1:0] status   | [10:0] key, [26:11] payload,
//          |           |                | [31:27] length
//
//  A pop, a head push and an ordered insert handle the entries one slot at
//  a time: each slot touched gets a memory read and then a write or a
//  compare. A full push, an empty pop and a tail push do not scan or shift.
//  in_tready is high only while the sequencer is idle; a finished result
//  waits in the output register while the next item is taken.
//  Reset (rst_n low, synchronous) empties the queue; memory is not cleared.
// ----------------------------------------------------------------------------
module sorted_insert_queue #(
  parameter int CAPACITY = siq_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [10:0] entry_key, [26:11] entry_payload
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [10:0] out_key, [26:11] out_payload,
                                  // [31:27] length
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int KW    = siq_pkg::KEY_W;
  localparam int PW    = siq_pkg::PAY_W;
  localparam int EW    = siq_pkg::ENTRY_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Entry store: {key, payload}
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic wr_en;

  siq_pkg::state_t state_r, state_nxt;
  siq_pkg::op_t    op_r, op_nxt;
  siq_pkg::status_t st_r, st_nxt;
  logic [KW-1:0]    key_r, key_nxt;
  logic [PW-1:0]    pay_r, pay_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [EW-1:0]    pop_r, pop_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_data_r, out_data_nxt;
  logic [1:0]       out_user_r, out_user_nxt;

  logic             in_xfer;
  logic             out_free;
  logic             key_gt;
  logic [CNT_W-1:0] idx_inc, idx_dec;
  logic [31:0]      len_ext;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Shared compare and index step unit
  assign key_gt  = rd_data_r[PW +: KW] > key_r;
  assign idx_inc = idx_r + CNT_W'(1);
  assign idx_dec = idx_r - CNT_W'(1);
  assign len_ext = 32'(count_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      siq_pkg::S_IDLE: begin
        if (in_xfer) state_nxt = siq_pkg::S_DISPATCH;
      end
      siq_pkg::S_DISPATCH: begin
        if (op_r == siq_pkg::OP_POP) begin
          state_nxt = (count_r == '0) ? siq_pkg::S_FINISH : siq_pkg::S_POP_RD;
        end else if (count_r == CAP_CNT) begin
          state_nxt = siq_pkg::S_FINISH;
        end else if (op_r == siq_pkg::OP_PUSH_TAIL || count_r == '0) begin
          state_nxt = siq_pkg::S_WRITE;
        end else if (op_r == siq_pkg::OP_PUSH_HEAD) begin
          state_nxt = siq_pkg::S_UP_RD;
        end else begin
          state_nxt = siq_pkg::S_SEARCH_RD;
        end
      end
      siq_pkg::S_SEARCH_RD: state_nxt = siq_pkg::S_SEARCH_CMP;
      siq_pkg::S_SEARCH_CMP: begin
        if (key_gt) begin
          state_nxt = siq_pkg::S_UP_RD;
        end else if (idx_inc == count_r) begin
          state_nxt = siq_pkg::S_WRITE;
        end else begin
          state_nxt = siq_pkg::S_SEARCH_RD;
        end
      end
      siq_pkg::S_UP_RD: state_nxt = siq_pkg::S_UP_WR;
      siq_pkg::S_UP_WR: begin
        state_nxt = (idx_dec == pos_r) ? siq_pkg::S_WRITE : siq_pkg::S_UP_RD;
      end
      siq_pkg::S_WRITE:  state_nxt = siq_pkg::S_FINISH;
      siq_pkg::S_POP_RD: state_nxt = siq_pkg::S_POP_CAP;
      siq_pkg::S_POP_CAP: begin
        state_nxt = (count_r == CNT_W'(1)) ? siq_pkg::S_FINISH : siq_pkg::S_DN_RD;
      end
      siq_pkg::S_DN_RD: state_nxt = siq_pkg::S_DN_WR;
      siq_pkg::S_DN_WR: begin
        state_nxt = (idx_inc == count_r) ? siq_pkg::S_FINISH : siq_pkg::S_DN_RD;
      end
      siq_pkg::S_FINISH: begin
        if (out_free) state_nxt = siq_pkg::S_IDLE;
      end
      default: state_nxt = siq_pkg::S_IDLE;
    endcase
  end

  // Memory control outputs
  always_comb begin
    rd_addr = '0;
    wr_addr = pos_r[IDX_W-1:0];
    wr_data = {key_r, pay_r};
    wr_en   = 1'b0;
    unique case (state_r)
      siq_pkg::S_SEARCH_RD: rd_addr = idx_r[IDX_W-1:0];
      siq_pkg::S_UP_RD:     rd_addr = idx_dec[IDX_W-1:0];
      siq_pkg::S_DN_RD:     rd_addr = idx_r[IDX_W-1:0];
      siq_pkg::S_UP_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[IDX_W-1:0];
        wr_data = rd_data_r;
      end
      siq_pkg::S_DN_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_dec[IDX_W-1:0];
        wr_data = rd_data_r;
      end
      siq_pkg::S_WRITE: wr_en = 1'b1;
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    st_nxt        = st_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    pop_nxt       = pop_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    case (state_r)
      siq_pkg::S_IDLE: begin
        // capture the item
        if (in_xfer) begin
          op_nxt  = siq_pkg::op_t'(in_tuser);
          key_nxt = in_tdata[KW-1:0];
          pay_nxt = in_tdata[KW +: PW];
        end
      end
      siq_pkg::S_DISPATCH: begin
        pop_nxt = '0;
        idx_nxt = '0;
        st_nxt  = siq_pkg::ST_OK;
        if (op_r == siq_pkg::OP_POP) begin
          if (count_r == '0) st_nxt = siq_pkg::ST_EMPTY;
        end else if (count_r == CAP_CNT) begin
          st_nxt = siq_pkg::ST_FULL;
        end else if (op_r == siq_pkg::OP_PUSH_TAIL) begin
          pos_nxt = count_r;
        end else begin
          // head push opens the gap at slot 0; insert starts its scan there
          pos_nxt = '0;
          if (op_r == siq_pkg::OP_PUSH_HEAD) idx_nxt = count_r;
        end
      end
      siq_pkg::S_SEARCH_CMP: begin
        // stop at the first key strictly greater
        if (key_gt) begin
          pos_nxt = idx_r;
          idx_nxt = count_r;
        end else begin
          idx_nxt = idx_inc;
          pos_nxt = idx_inc;
        end
      end
      siq_pkg::S_UP_WR:  idx_nxt = idx_dec;
      siq_pkg::S_WRITE:  count_nxt = count_r + CNT_W'(1);
      siq_pkg::S_POP_CAP: begin
        pop_nxt = rd_data_r;
        idx_nxt = CNT_W'(1);
        if (count_r == CNT_W'(1)) count_nxt = '0;
      end
      siq_pkg::S_DN_WR: begin
        idx_nxt = idx_inc;
        if (idx_inc == count_r) count_nxt = count_r - CNT_W'(1);
      end
      siq_pkg::S_FINISH: begin
        // load the result register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {len_ext[siq_pkg::LEN_W-1:0], pop_r[PW-1:0], pop_r[PW +: KW]};
          out_user_nxt  = st_r;
        end
      end
      default: ;
    endcase
  end

  // Entry store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= siq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    st_r       <= st_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    pop_r      <= pop_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == siq_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: design/siq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siq_port_checks: port-level checks for the sorted insert queue
// Watches the stream ports and flags result or handshake slips.
// ----------------------------------------------------------------------------
module siq_port_checks #(
  parameter int CAPACITY = siq_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  localparam logic [4:0] FULL_LEN = 5'(CAPACITY % 32);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Block is busy in the cycle after a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a second item back to back");

  // Pop on empty reports zero entry and zero length
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == siq_pkg::ST_EMPTY |-> out_tdata == 32'd0)
    else $error("empty pop carries data");

  // Dropped insert reports a full queue and no entry
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == siq_pkg::ST_FULL
      |-> out_tdata[31:27] == FULL_LEN && out_tdata[26:0] == 27'd0)
    else $error("full status with wrong length or data");

  // Only defined status codes appear
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == siq_pkg::ST_OK || out_tuser == siq_pkg::ST_EMPTY ||
                   out_tuser == siq_pkg::ST_FULL)
    else $error("undefined status code");

endmodule

bind sorted_insert_queue siq_port_checks #(.CAPACITY(CAPACITY)) u_siq_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: dv/siq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siq_checker: result checker for the sorted insert queue
// Watches both stream channels and keeps its own copy of the queue. For every
// accepted command it works out the result the block must return: the popped
// entry or zeros, the status and the new length. It then compares each
// accepted result, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module siq_checker #(
  parameter int CAPACITY = siq_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,    // [10:0] entry_key, [26:11] entry_payload
  input  logic [1:0]  in_tuser,    // [1:0] op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,   // [10:0] out_key, [26:11] out_payload,
                                   // [31:27] length
  input  logic [1:0]  out_tuser,   // [1:0] status
  input  logic        end_check,
  output int          mismatches,
  output int          pending
);

  localparam int KEY_W   = siq_pkg::KEY_W;
  localparam int PAY_W   = siq_pkg::PAY_W;
  localparam int ST_W    = siq_pkg::ST_W;
  localparam int LEN_W   = siq_pkg::LEN_W;
  localparam int ENTRY_W = siq_pkg::ENTRY_W;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [ST_W-1:0]  status;
    logic [LEN_W-1:0] length;
  } queue_result_t;

  // Shadow of the queue contents, head first, and results still owed
  entry_t        shadow_queue[$];
  queue_result_t owed_results[$];
  bit            end_done;

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Apply one command to the shadow queue and return the result it owes
  function automatic queue_result_t apply_command(siq_pkg::op_t op, entry_t item);
    queue_result_t res;
    int            pos;
    res        = '0;
    res.status = siq_pkg::ST_OK;
    if (op == siq_pkg::OP_POP) begin
      if (shadow_queue.size() == 0) begin
        res.status = siq_pkg::ST_EMPTY;
      end else begin
        res.key     = shadow_queue[0].key;
        res.payload = shadow_queue[0].payload;
        shadow_queue.delete(0);
      end
    end else if (shadow_queue.size() >= CAPACITY) begin
      res.status = siq_pkg::ST_FULL;
    end else begin
      case (op)
        siq_pkg::OP_PUSH_HEAD: begin
          shadow_queue.push_front(item);
        end
        siq_pkg::OP_PUSH_TAIL: begin
          shadow_queue.push_back(item);
        end
        default: begin
          // Stable insert: go past every entry with key less or equal
          pos = 0;
          while (pos < shadow_queue.size() && shadow_queue[pos].key <= item.key)
            pos++;
          shadow_queue.insert(pos, item);
        end
      endcase
    end
    res.length = LEN_W'(shadow_queue.size());
    return res;
  endfunction

  always @(posedge clk) begin
    entry_t        item;
    queue_result_t got;
    queue_result_t want;
    if (!rst_n) begin
      shadow_queue.delete();
      owed_results.delete();
      end_done = 1'b0;
    end else begin
      // Predict on every accepted command transfer
      if (in_tvalid && in_tready) begin
        item.key     = in_tdata[KEY_W-1:0];
        item.payload = in_tdata[KEY_W +: PAY_W];
        owed_results.push_back(apply_command(siq_pkg::op_t'(in_tuser), item));
      end

      // Compare every accepted result transfer with the oldest prediction
      if (out_tvalid && out_tready) begin
        got.key     = out_tdata[KEY_W-1:0];
        got.payload = out_tdata[KEY_W +: PAY_W];
        got.length  = out_tdata[ENTRY_W +: LEN_W];
        got.status  = out_tuser;
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result key %0d payload %0h status %0d len %0d",
                                    got.key, got.payload, got.status, got.length));
        end else begin
          want = owed_results.pop_front();
          if (got.key !== want.key)
            report_mismatch($sformatf("key got %0d want %0d", got.key, want.key));
          if (got.payload !== want.payload)
            report_mismatch($sformatf("payload got %0h want %0h",
                                      got.payload, want.payload));
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      got.status, want.status));
          if (got.length !== want.length)
            report_mismatch($sformatf("length got %0d want %0d",
                                      got.length, want.length));
        end
      end

      // Flag results that never arrived
      if (end_check && !end_done) begin
        end_done = 1'b1;
        if (owed_results.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
      end
    end
    pending <= owed_results.size();
  end

endmodule

// File: dv/tb_sorted_insert_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_insert_queue: testbench for the sorted insert queue
// Drives a directed command list (empty pop, all pushes, equal keys, key
// extremes, full queue) and then random fill, drain and mixed bursts with
// random sender gaps and receiver stalls, one long receiver hold-off and
// full drains. Checking is done by siq_checker and the bound siq_port_checks.
// ----------------------------------------------------------------------------
module tb_sorted_insert_queue;

  localparam int CAP         = siq_pkg::CAPACITY_DEF;
  localparam int KEY_W       = siq_pkg::KEY_W;
  localparam int PAY_W       = siq_pkg::PAY_W;
  localparam int RUN_ITEMS   = 1700;
  localparam int QUIET_ITEMS = 150;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 60;
  localparam int CYCLE_LIMIT = 600000;

  localparam int TREND_FILL  = 0;
  localparam int TREND_DRAIN = 1;
  localparam int TREND_MIXED = 2;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [10:0] entry_key, [26:11] entry_payload
  logic [1:0]  in_tuser;    // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [10:0] out_key, [26:11] out_payload, [31:27] length
  logic [1:0]  out_tuser;   // [1:0] status
  logic        end_check;
  int          mismatches;
  int          pending;

  int          cycle_count = 0;
  int          idle_pct    = 0;
  bit          quiet       = 1'b0;
  bit          hold_req    = 1'b0;
  bit          hold_done   = 1'b0;
  logic [KEY_W-1:0] cluster_base = '0;

  always #10 clk = ~clk;

  sorted_insert_queue #(.CAPACITY(CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  siq_checker #(.CAPACITY(CAP)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .end_check  (end_check),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one command, optionally after an idle burst, and hold until taken
  task automatic offer(siq_pkg::op_t op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= 32'({pay, key});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every owed result has been taken
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Keys: legal minutes, any 11-bit value, a tight cluster of repeats, extremes
  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return KEY_W'($urandom_range(0, 1439));
    if (roll < 60) return KEY_W'($urandom_range(0, 2047));
    if (roll < 90) return cluster_base + KEY_W'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return KEY_W'(1439);
      2:       return KEY_W'(1440);
      default: return '1;
    endcase
  endfunction

  function automatic siq_pkg::op_t pick_op(int trend);
    int roll;
    roll = $urandom_range(0, 99);
    case (trend)
      TREND_FILL: begin
        if (roll < 15) return siq_pkg::OP_POP;
        if (roll < 70) return siq_pkg::OP_INSERT;
        if (roll < 85) return siq_pkg::OP_PUSH_HEAD;
        return siq_pkg::OP_PUSH_TAIL;
      end
      TREND_DRAIN: begin
        if (roll < 70) return siq_pkg::OP_POP;
        if (roll < 80) return siq_pkg::OP_INSERT;
        if (roll < 90) return siq_pkg::OP_PUSH_HEAD;
        return siq_pkg::OP_PUSH_TAIL;
      end
      default: begin
        if (roll < 45) return siq_pkg::OP_POP;
        if (roll < 80) return siq_pkg::OP_INSERT;
        if (roll < 90) return siq_pkg::OP_PUSH_HEAD;
        return siq_pkg::OP_PUSH_TAIL;
      end
    endcase
  endfunction

  // Result side: random stalls, one long hold-off, none in the quiet tail
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // Command side
  initial begin
    int trend;
    int burst_len;
    int burst_idx;
    int random_sent;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= siq_pkg::OP_PUSH_HEAD;
    end_check <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, every push kind, equal keys, key extremes
    idle_pct = 30;
    offer(siq_pkg::OP_POP,       11'd0,    16'h0000);
    offer(siq_pkg::OP_INSERT,    11'd100,  16'h5555);
    offer(siq_pkg::OP_INSERT,    11'd100,  16'hAAAA);
    offer(siq_pkg::OP_PUSH_HEAD, 11'd0,    16'h0000);
    offer(siq_pkg::OP_PUSH_TAIL, 11'd2047, 16'hFFFF);
    offer(siq_pkg::OP_INSERT,    11'd1439, 16'h1439);
    offer(siq_pkg::OP_INSERT,    11'd2047, 16'h2047);
    offer(siq_pkg::OP_INSERT,    11'd0,    16'h0001);
    offer(siq_pkg::OP_POP,       11'd2047, 16'hFFFF);
    // Fill up to capacity
    offer(siq_pkg::OP_INSERT,    11'd1440, 16'h1440);
    offer(siq_pkg::OP_INSERT,    11'd5,    16'h8001);
    offer(siq_pkg::OP_INSERT,    11'd1024, 16'h7FFE);
    offer(siq_pkg::OP_INSERT,    11'd100,  16'hC3C3);
    offer(siq_pkg::OP_PUSH_TAIL, 11'd1,    16'h3C3C);
    offer(siq_pkg::OP_INSERT,    11'd1023, 16'h0F0F);
    offer(siq_pkg::OP_PUSH_HEAD, 11'd1439, 16'hF0F0);
    offer(siq_pkg::OP_INSERT,    11'd2046, 16'h00FF);
    offer(siq_pkg::OP_INSERT,    11'd512,  16'hFF00);
    offer(siq_pkg::OP_INSERT,    11'd0,    16'h1234);
    // Queue full: every push kind is dropped
    offer(siq_pkg::OP_PUSH_HEAD, 11'd7,    16'hDEAD);
    offer(siq_pkg::OP_PUSH_TAIL, 11'd8,    16'hBEEF);
    offer(siq_pkg::OP_INSERT,    11'd9,    16'hCAFE);
    offer(siq_pkg::OP_POP,       11'd0,    16'h0000);
    wait_drained();

    // Random bursts that trend toward full, toward empty, or stay mixed
    random_sent = 0;
    burst_idx   = 0;
    while (random_sent < RUN_ITEMS) begin
      trend        = $urandom_range(TREND_FILL, TREND_MIXED);
      burst_len    = $urandom_range(20, 60);
      cluster_base = KEY_W'($urandom_range(0, 2044));
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 25;
        default: idle_pct = 60;
      endcase
      repeat (burst_len) begin
        if (random_sent >= RUN_ITEMS - QUIET_ITEMS) quiet = 1'b1;
        if (random_sent == 300) hold_req = 1'b1;
        offer(pick_op(trend), pick_key(), PAY_W'($urandom_range(0, 65535)));
        random_sent++;
      end
      burst_idx++;
      // Let everything settle now and then
      if (burst_idx % 6 == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sorted_insert_queue.f
design/siq_pkg.sv
design/sorted_insert_queue.sv
design/siq_checker.sv
dv/siq_checker.sv
dv/tb_sorted_insert_queue.sv
